// ----- rtl/core/hmmbc_pkg.sv -----
package hmmbc_pkg;

   // Fixed field widths
   localparam int RegionWidth   = 4;
   localparam int OffsetWidth   = 21;
   localparam int AddressWidth  = 16;
   localparam int DataWidth     = 8;
   localparam int MaxBankBits   = 7;
   localparam int WindowBits    = 14;

   // Region codes
   localparam logic [RegionWidth-1:0] REGION_ROM0   = 4'd0;
   localparam logic [RegionWidth-1:0] REGION_ROMN   = 4'd1;
   localparam logic [RegionWidth-1:0] REGION_VRAM   = 4'd2;
   localparam logic [RegionWidth-1:0] REGION_EXTRAM = 4'd3;
   localparam logic [RegionWidth-1:0] REGION_WRAM   = 4'd4;
   localparam logic [RegionWidth-1:0] REGION_OAM    = 4'd5;
   localparam logic [RegionWidth-1:0] REGION_IO     = 4'd6;
   localparam logic [RegionWidth-1:0] REGION_HRAM   = 4'd7;
   localparam logic [RegionWidth-1:0] REGION_KEYPAD = 4'd8;
   localparam logic [RegionWidth-1:0] REGION_NONE   = 4'd9;
   localparam logic [RegionWidth-1:0] REGION_CTRL   = 4'd10;

   // Access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Map boundaries
   localparam logic [AddressWidth-1:0] ADDR_ROMN     = 16'h4000;
   localparam logic [AddressWidth-1:0] ADDR_VRAM     = 16'h8000;
   localparam logic [AddressWidth-1:0] ADDR_EXTRAM   = 16'hA000;
   localparam logic [AddressWidth-1:0] ADDR_WRAM     = 16'hC000;
   localparam logic [AddressWidth-1:0] ADDR_ECHO     = 16'hE000;
   localparam logic [AddressWidth-1:0] ADDR_OAM      = 16'hFE00;
   localparam logic [AddressWidth-1:0] ADDR_UNMAPPED = 16'hFEA0;
   localparam logic [AddressWidth-1:0] ADDR_KEYPAD   = 16'hFF00;
   localparam logic [AddressWidth-1:0] ADDR_HRAM     = 16'hFF80;
   localparam logic [AddressWidth-1:0] ADDR_DMA      = 16'hFF46;
   localparam logic [AddressWidth-1:0] ADDR_LCD_LO   = 16'hFF40;
   localparam logic [AddressWidth-1:0] ADDR_LCD_HI   = 16'hFF44;
   localparam logic [AddressWidth-1:0] ADDR_PAL_LO   = 16'hFF47;
   localparam logic [AddressWidth-1:0] ADDR_PAL_HI   = 16'hFF4B;

   // Bank controller register selects (address bits 14:13)
   localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
   localparam logic [1:0] SEL_BANK_LOW   = 2'd1;
   localparam logic [1:0] SEL_BANK_HIGH  = 2'd2;
   localparam logic [1:0] SEL_MODE       = 2'd3;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic       MODE_ROM       = 1'b0;

   // Decoded access
   typedef struct packed {
      logic [RegionWidth-1:0] region;
      logic [OffsetWidth-1:0] physical_offset;
      logic                   store_strobe;
      logic                   display_changed;
      logic                   dma_start;
      logic                   ctrl_write;
   } decode_type;

   // Bank controller write
   typedef struct packed {
      logic                 enable;
      logic [1:0]           sel;
      logic [DataWidth-1:0] data;
   } ctrl_write_type;

endpackage

// ----- rtl/core/hmmbc_channels.sv -----
interface hmmbc_req_if;
   import hmmbc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [AddressWidth-1:0] address;
   logic [DataWidth-1:0]    write_data;

   modport source (output valid, output func, output address, output write_data,
                   input ready);
   modport sink   (input valid, input func, input address, input write_data,
                   output ready);
endinterface

interface hmmbc_rsp_if;
   import hmmbc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [RegionWidth-1:0]       region;
   logic [OffsetWidth-1:0]       physical_offset;
   logic                         store_strobe;
   logic                         display_changed;
   logic                         dma_start;
   logic                         ext_ram_enabled;
   logic [MaxBankBits-1:0]       current_rom_bank;

   modport source (output valid, output region, output physical_offset,
                   output store_strobe, output display_changed, output dma_start,
                   output ext_ram_enabled, output current_rom_bank, input ready);
   modport sink   (input valid, input region, input physical_offset,
                   input store_strobe, input display_changed, input dma_start,
                   input ext_ram_enabled, input current_rom_bank, output ready);
endinterface

// ----- rtl/core/hmmbc_decode.sv -----
module hmmbc_decode #(
   parameter int BANK_BITS = 7
) (
   input  logic                                func,
   input  logic [hmmbc_pkg::AddressWidth-1:0]  address,
   input  logic [BANK_BITS-1:0]                active_bank,
   output hmmbc_pkg::decode_type               decode
);
   import hmmbc_pkg::*;

   logic is_display_reg;

   assign is_display_reg = ((address >= ADDR_LCD_LO) && (address <= ADDR_LCD_HI)) ||
                           ((address >= ADDR_PAL_LO) && (address <= ADDR_PAL_HI));

   always_comb begin
      decode = '0;

      // Walk the address map
      priority if (address < ADDR_ROMN) begin
         decode.region          = REGION_ROM0;
         decode.physical_offset = OffsetWidth'(address[WindowBits-1:0]);
      end else if (address < ADDR_VRAM) begin
         decode.region          = REGION_ROMN;
         decode.physical_offset = OffsetWidth'({active_bank, address[WindowBits-1:0]});
      end else if (address < ADDR_EXTRAM) begin
         decode.region          = REGION_VRAM;
         decode.physical_offset = OffsetWidth'(address[12:0]);
         decode.display_changed = 1'b1;
         decode.store_strobe    = 1'b1;
      end else if (address < ADDR_WRAM) begin
         decode.region          = REGION_EXTRAM;
         decode.physical_offset = OffsetWidth'(address[12:0]);
         decode.store_strobe    = 1'b1;
      end else if (address < ADDR_OAM) begin
         // Work RAM and its echo share the low 13 bits
         decode.region          = REGION_WRAM;
         decode.physical_offset = OffsetWidth'(address[12:0]);
         decode.store_strobe    = 1'b1;
      end else if (address < ADDR_UNMAPPED) begin
         decode.region          = REGION_OAM;
         decode.physical_offset = OffsetWidth'(address[7:0]);
         decode.display_changed = 1'b1;
         decode.store_strobe    = 1'b1;
      end else if (address < ADDR_KEYPAD) begin
         decode.region          = REGION_NONE;
      end else if (address == ADDR_KEYPAD) begin
         decode.region          = REGION_KEYPAD;
         decode.store_strobe    = 1'b1;
      end else if (address < ADDR_HRAM) begin
         decode.region          = REGION_IO;
         decode.physical_offset = OffsetWidth'(address[7:0]);
         if (address == ADDR_DMA) begin
            decode.dma_start       = 1'b1;
            decode.display_changed = 1'b1;
         end else begin
            decode.store_strobe    = 1'b1;
            decode.display_changed = is_display_reg;
         end
      end else begin
         decode.region          = REGION_HRAM;
         decode.physical_offset = OffsetWidth'(address[6:0]);
         decode.store_strobe    = 1'b1;
      end

      // Apply access kind: writes to ROM space hit the bank controller; reads clear the strobes
      if (func == FUNC_WRITE) begin
         if (address < ADDR_VRAM) begin
            decode.region          = REGION_CTRL;
            decode.physical_offset = '0;
            decode.store_strobe    = 1'b0;
            decode.ctrl_write      = 1'b1;
         end
      end else begin
         decode.store_strobe    = 1'b0;
         decode.display_changed = 1'b0;
         decode.dma_start       = 1'b0;
      end
   end

endmodule

// ----- rtl/core/hmmbc_bank_regs.sv -----
module hmmbc_bank_regs #(
   parameter int BANK_BITS = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hmmbc_pkg::ctrl_write_type      ctrl_wr,
   output logic [BANK_BITS-1:0]           active_bank,
   output logic [BANK_BITS-1:0]           active_bank_next,
   output logic                           extram_enable_next
);
   import hmmbc_pkg::*;

   logic [BANK_BITS-1:0]   active_bank_ff;
   logic [BANK_BITS-1:0]   active_bank_in;
   logic                   banking_mode_ff;
   logic                   banking_mode_in;
   logic                   extram_enable_ff;
   logic                   extram_enable_in;
   logic [MaxBankBits-1:0] bank_wide;
   logic [MaxBankBits-1:0] bank_wide_in;
   logic [4:0]             low_field;

   assign bank_wide = MaxBankBits'(active_bank_ff);
   assign low_field = (ctrl_wr.data[4:0] == 5'd0) ? 5'd1 : ctrl_wr.data[4:0];

   // Next register values for a control write
   always_comb begin
      bank_wide_in     = bank_wide;
      banking_mode_in  = banking_mode_ff;
      extram_enable_in = extram_enable_ff;
      if (ctrl_wr.enable) begin
         unique case (ctrl_wr.sel)
            SEL_RAM_ENABLE: extram_enable_in = (ctrl_wr.data[3:0] == RAM_ENABLE_KEY);
            SEL_BANK_LOW:   bank_wide_in     = {bank_wide[6:5], low_field};
            SEL_BANK_HIGH: begin
               if (banking_mode_ff == MODE_ROM) begin
                  bank_wide_in = {ctrl_wr.data[1:0], bank_wide[4:0]};
               end
            end
            SEL_MODE:       banking_mode_in  = ctrl_wr.data[0];
            default:        bank_wide_in     = bank_wide;
         endcase
      end
   end

   assign active_bank_in = bank_wide_in[BANK_BITS-1:0];

   // Hold bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff   <= BANK_BITS'(1);
         banking_mode_ff  <= MODE_ROM;
         extram_enable_ff <= 1'b0;
      end else begin
         active_bank_ff   <= active_bank_in;
         banking_mode_ff  <= banking_mode_in;
         extram_enable_ff <= extram_enable_in;
      end
   end

   assign active_bank        = active_bank_ff;
   assign active_bank_next   = active_bank_in;
   assign extram_enable_next = extram_enable_in;

endmodule

// ----- rtl/core/handheld_memory_map_bank_controller_top.sv -----
// Channel   Dir  Payload                                     Handshake
// req_bus   in   func, address, write_data                    valid/ready
// rsp_bus   out  region, physical_offset, store_strobe,       valid/ready
//                display_changed, dma_start, ext_ram_enabled,
//                current_rom_bank
//
// One request per cycle while the response side is not stalled; each request goes
// through the input register, then decode and bank update into the output register.
// Reset is synchronous and sets ROM bank 1, ROM mode and external RAM disabled.
// A stalled response holds the output register, and the input register then takes a
// request only while it is empty; unstalled, it also takes one in the same cycle that its request moves on.
module handheld_memory_map_bank_controller_top #(
   parameter int BANK_BITS = 7
) (
   input  logic        clock,
   input  logic        reset,
   hmmbc_req_if.sink   req_bus,
   hmmbc_rsp_if.source rsp_bus
);
   import hmmbc_pkg::*;

   logic                    in_valid_ff;
   logic                    in_func_ff;
   logic [AddressWidth-1:0] in_address_ff;
   logic [DataWidth-1:0]    in_data_ff;

   logic                    out_valid_ff;
   logic [RegionWidth-1:0]  out_region_ff;
   logic [OffsetWidth-1:0]  out_offset_ff;
   logic                    out_strobe_ff;
   logic                    out_display_ff;
   logic                    out_dma_ff;
   logic                    out_enable_ff;
   logic [MaxBankBits-1:0]  out_bank_ff;

   logic                    out_open;
   logic                    in_advance;
   logic                    req_take;
   logic                    in_valid_in;
   logic                    out_valid_in;

   decode_type              decode;
   ctrl_write_type          ctrl_wr;
   logic [BANK_BITS-1:0]    active_bank;
   logic [BANK_BITS-1:0]    active_bank_next;
   logic                    extram_enable_next;

   // Handshake: the output register frees up when empty or drained
   assign out_open      = !out_valid_ff || rsp_bus.ready;
   assign in_advance    = in_valid_ff && out_open;
   assign req_bus.ready = !in_valid_ff || out_open;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_open);
   assign out_valid_in = in_advance || (out_valid_ff && !rsp_bus.ready);

   // Capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_func_ff    <= req_bus.func;
         in_address_ff <= req_bus.address;
         in_data_ff    <= req_bus.write_data;
      end
   end

   hmmbc_decode #(
      .BANK_BITS (BANK_BITS)
   ) u_decode (
      .func        (in_func_ff),
      .address     (in_address_ff),
      .active_bank (active_bank),
      .decode      (decode)
   );

   // Update bank registers only when the request moves to the output
   assign ctrl_wr.enable = in_advance && decode.ctrl_write;
   assign ctrl_wr.sel    = in_address_ff[14:13];
   assign ctrl_wr.data   = in_data_ff;

   hmmbc_bank_regs #(
      .BANK_BITS (BANK_BITS)
   ) u_bank_regs (
      .clock              (clock),
      .reset              (reset),
      .ctrl_wr            (ctrl_wr),
      .active_bank        (active_bank),
      .active_bank_next   (active_bank_next),
      .extram_enable_next (extram_enable_next)
   );

   // Register response
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (in_advance) begin
         out_region_ff  <= decode.region;
         out_offset_ff  <= decode.physical_offset;
         out_strobe_ff  <= decode.store_strobe;
         out_display_ff <= decode.display_changed;
         out_dma_ff     <= decode.dma_start;
         out_enable_ff  <= extram_enable_next;
         out_bank_ff    <= MaxBankBits'(active_bank_next);
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.region           = out_region_ff;
   assign rsp_bus.physical_offset  = out_offset_ff;
   assign rsp_bus.store_strobe     = out_strobe_ff;
   assign rsp_bus.display_changed  = out_display_ff;
   assign rsp_bus.dma_start        = out_dma_ff;
   assign rsp_bus.ext_ram_enabled  = out_enable_ff;
   assign rsp_bus.current_rom_bank = out_bank_ff;

endmodule
